### design/crrf_pkg.sv
// Package: constants, codes and types shared by the CAN range route forwarder.
package crrf_pkg;

  localparam int ROUTE_SLOTS = 8;
  localparam int QUEUE_DEPTH = 16;
  localparam int MAX_RESULTS = 16;
  localparam int RW = $clog2(ROUTE_SLOTS);
  localparam int QW = $clog2(QUEUE_DEPTH);
  localparam int ID_W = 29;
  // route entry: active, src, dst, kind, lo, hi
  localparam int ROUTE_W = 1 + 1 + 1 + 1 + ID_W + ID_W;
  // queue entry: chan, kind, id, len, data
  localparam int QENT_W = 1 + 1 + ID_W + 4 + 64;

  localparam logic [2:0] MODE_FRAME  = 3'd0;
  localparam logic [2:0] MODE_ADD    = 3'd1;
  localparam logic [2:0] MODE_REMOVE = 3'd2;
  localparam logic [2:0] MODE_DRAIN  = 3'd3;
  localparam logic [2:0] MODE_CLEAR  = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_INVAL = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  typedef struct packed {
    logic            active;
    logic            src;
    logic            dst;
    logic            kind;
    logic [ID_W-1:0] lo;
    logic [ID_W-1:0] hi;
  } route_t;

  typedef struct packed {
    logic            chan;
    logic            kind;
    logic [ID_W-1:0] id;
    logic [3:0]      len;
    logic [63:0]     data;
  } qent_t;

endpackage

### design/crrf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module crrf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### design/can_range_route_forwarder_unit.sv
// Top level of the CAN range route forwarder: route table, queue and sequencer.
//
// Two-channel CAN gateway. Routes live in a small synchronous RAM, queued
// frames in a second one; both have registered reads. A received frame walks
// the used route slots one at a time (read a slot in S_SCAN, then in S_CMP
// compare it and push a copy to the queue RAM on a match while the queue has
// room). Add, remove, clear, unknown modes and an empty drain go straight to
// S_RESP, which waits for the output register to free up. A drain streams
// queued words from the queue RAM read port, reading each in S_DRAIN and
// loading it in S_DOUT, at most 16 per drain item, flagged last on the final
// one. Route slot validity is held in flip-flops, so no clearing pass is
// needed after reset. The block works on one item at a time: in_ready is high
// only in idle. A single-word result is loaded into the output register and
// may still wait there while the next item is accepted; that item's own
// result waits until the register is free. A drain holds in_ready low until
// its last word has been taken.
module can_range_route_forwarder_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [2:0]                   mode,
  input  logic                         source_channel,
  input  logic                         dest_channel,
  input  logic                         frame_kind,
  input  logic [crrf_pkg::ID_W-1:0]    message_id,
  input  logic [crrf_pkg::ID_W-1:0]    id_low,
  input  logic [crrf_pkg::ID_W-1:0]    id_high,
  input  logic [3:0]                   byte_count,
  input  logic [63:0]                  payload,
  input  logic [2:0]                   route_index,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   status,
  output logic                         is_frame,
  output logic [2:0]                   added_index,
  output logic                         out_channel,
  output logic                         out_kind,
  output logic [crrf_pkg::ID_W-1:0]    out_id,
  output logic [3:0]                   out_length,
  output logic [63:0]                  out_payload,
  output logic [31:0]                  forwarded_total,
  output logic [4:0]                   queued_now,
  output logic                         last
);
  import crrf_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_CMP   = 6'b000100,
    S_DRAIN = 6'b001000,
    S_DOUT  = 6'b010000,
    S_RESP  = 6'b100000
  } state_t;

  state_t state;

  // latched input word
  logic [2:0]      c_mode;
  logic            c_src, c_dst, c_kind;
  logic [ID_W-1:0] c_id, c_lo, c_hi;
  logic [3:0]      c_len;
  logic [63:0]     c_data;
  logic [2:0]      c_ridx;

  logic [ROUTE_SLOTS-1:0] slot_valid;
  logic [RW:0]            routes_used;
  logic [31:0]            match_count;
  logic [QW-1:0]          write_pointer, read_pointer;
  logic [QW:0]            fill_level;
  logic [RW:0]            scan_idx;
  logic [$clog2(MAX_RESULTS+1)-1:0] drained;

  // route RAM
  logic          rt_we;
  logic [RW-1:0] rt_waddr, rt_raddr;
  route_t        rt_wdata, rt_rdata;
  logic [ROUTE_W-1:0] rt_rbits;

  crrf_ram #(.WIDTH(ROUTE_W), .DEPTH(ROUTE_SLOTS)) u_route_ram (
    .clk(clk), .we(rt_we), .waddr(rt_waddr), .wdata(rt_wdata),
    .raddr(rt_raddr), .rdata(rt_rbits)
  );
  assign rt_rdata = route_t'(rt_rbits);

  // queue RAM
  logic          q_we;
  qent_t         q_wdata, q_rdata;
  logic [QENT_W-1:0] q_rbits;

  crrf_ram #(.WIDTH(QENT_W), .DEPTH(QUEUE_DEPTH)) u_queue_ram (
    .clk(clk), .we(q_we), .waddr(write_pointer), .wdata(q_wdata),
    .raddr(read_pointer), .rdata(q_rbits)
  );
  assign q_rdata = qent_t'(q_rbits);

  logic in_fire, out_fire, slot_in_range, hit, more_slots;
  logic       out_load;
  logic [1:0] resp_status;
  logic [2:0] resp_added;

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  logic [RW-1:0] rt_raddr_q;

  // compare stage sees slot scan_idx-1 in rt_rdata
  assign hit = slot_valid[rt_raddr_q] && rt_rdata.src == c_src &&
               rt_rdata.kind == c_kind && c_id >= rt_rdata.lo && c_id <= rt_rdata.hi;
  assign more_slots = (scan_idx < routes_used);
  assign slot_in_range = 1'b1;

  // status and slot of a single-word result
  always_comb begin
    resp_status = ST_OK;
    resp_added  = '0;
    case (c_mode)
      MODE_FRAME: ;
      MODE_ADD: begin
        if (routes_used >= (RW+1)'(ROUTE_SLOTS)) begin
          resp_status = ST_FULL;
        end else if (c_src == c_dst) begin
          resp_status = ST_INVAL;
        end else begin
          resp_added = 3'(routes_used);
        end
      end
      MODE_REMOVE: begin
        if ({1'b0, c_ridx} >= 4'(routes_used)) begin
          resp_status = ST_INVAL;
        end
      end
      MODE_DRAIN: resp_status = ST_EMPTY;
      MODE_CLEAR: ;
      default: resp_status = ST_INVAL;
    endcase
  end

  // load the output register with a drain word or a single-word result
  assign out_load = (state == S_DOUT && (!out_valid || out_fire)) ||
                    (state == S_RESP && !(c_mode == MODE_DRAIN && drained != '0) &&
                     !out_valid);

  always_comb begin
    rt_we    = 1'b0;
    rt_waddr = routes_used[RW-1:0];
    rt_wdata.active = 1'b1;
    rt_wdata.src    = c_src;
    rt_wdata.dst    = c_dst;
    rt_wdata.kind   = c_kind;
    rt_wdata.lo     = c_lo;
    rt_wdata.hi     = c_hi;
    q_we            = (state == S_CMP) && hit && (fill_level < (QW+1)'(QUEUE_DEPTH));
    q_wdata.chan    = rt_rdata.dst;
    q_wdata.kind    = c_kind;
    q_wdata.id      = c_id;
    q_wdata.len     = c_len;
    q_wdata.data    = c_data;
    if (state == S_RESP && c_mode == MODE_ADD && !out_valid && slot_in_range &&
        routes_used < (RW+1)'(ROUTE_SLOTS) && c_src != c_dst) begin
      rt_we = 1'b1;
    end
  end

  // issue the slot read straight from the scan index so the data lands in S_CMP
  assign rt_raddr = (state == S_SCAN) ? scan_idx[RW-1:0] : rt_raddr_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      slot_valid    <= '0;
      routes_used   <= '0;
      match_count   <= '0;
      write_pointer <= '0;
      read_pointer  <= '0;
      fill_level    <= '0;
      out_valid     <= 1'b0;
      scan_idx      <= '0;
      drained       <= '0;
      rt_raddr_q    <= '0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_fire) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            c_mode <= mode;  c_src <= source_channel; c_dst <= dest_channel;
            c_kind <= frame_kind; c_id <= message_id; c_lo <= id_low; c_hi <= id_high;
            c_len  <= (byte_count > 4'd8) ? 4'd8 : byte_count;
            c_data <= payload; c_ridx <= route_index;
            scan_idx   <= '0;
            drained    <= '0;
            rt_raddr_q <= '0;
            if (mode == MODE_FRAME) begin
              state <= S_SCAN;
            end else if (mode == MODE_DRAIN && fill_level != '0) begin
              state <= S_DRAIN;
            end else begin
              state <= S_RESP;
            end
          end
        end
        S_SCAN: begin
          // issue read of slot scan_idx, or finish
          if (more_slots) begin
            rt_raddr_q <= scan_idx[RW-1:0];
            scan_idx   <= scan_idx + 1'b1;
            state      <= S_CMP;
          end else begin
            state <= S_RESP;
          end
        end
        S_CMP: begin
          if (hit) begin
            match_count <= match_count + 32'd1;
            if (q_we) begin
              write_pointer <= write_pointer + 1'b1;
              fill_level    <= fill_level + 1'b1;
            end
          end
          state <= S_SCAN;
        end
        S_DRAIN: begin
          // read at read_pointer is in flight; S_DOUT loads it into the output register
          state <= S_DOUT;
        end
        S_DOUT: begin
          if (!out_valid || out_fire) begin
            status          <= ST_OK;
            is_frame        <= 1'b1;
            added_index     <= '0;
            out_channel     <= q_rdata.chan;
            out_kind        <= q_rdata.kind;
            out_id          <= q_rdata.id;
            out_length      <= q_rdata.len;
            out_payload     <= q_rdata.data;
            forwarded_total <= match_count;
            queued_now      <= 5'(fill_level - 1'b1);
            last            <= (fill_level == (QW+1)'(1)) ||
                               (drained == ($bits(drained))'(MAX_RESULTS - 1));
            read_pointer    <= read_pointer + 1'b1;
            fill_level      <= fill_level - 1'b1;
            drained         <= drained + 1'b1;
            if ((fill_level == (QW+1)'(1)) ||
                (drained == ($bits(drained))'(MAX_RESULTS - 1))) begin
              state <= S_RESP;
              c_mode <= MODE_DRAIN;
            end else begin
              state <= S_DRAIN;
            end
          end
        end
        S_RESP: begin
          if (c_mode == MODE_DRAIN && drained != '0) begin
            // drain results already sent; wait for the final word
            if (!out_valid || out_fire) begin
              state <= S_IDLE;
            end
          end else if (!out_valid) begin
            is_frame        <= 1'b0;
            added_index     <= resp_added;
            out_channel     <= 1'b0;
            out_kind        <= 1'b0;
            out_id          <= '0;
            out_length      <= '0;
            out_payload     <= '0;
            forwarded_total <= (c_mode == MODE_CLEAR) ? 32'd0 : match_count;
            queued_now      <= 5'(fill_level);
            last            <= 1'b1;
            status          <= resp_status;
            case (c_mode)
              MODE_ADD: begin
                if (resp_status == ST_OK) begin
                  slot_valid[routes_used[RW-1:0]] <= 1'b1;
                  routes_used <= routes_used + 1'b1;
                end
              end
              MODE_REMOVE: begin
                if (resp_status == ST_OK) begin
                  slot_valid[c_ridx[RW-1:0]] <= 1'b0;
                end
              end
              MODE_CLEAR: begin
                match_count <= '0;
              end
              default: ;
            endcase
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
